@@ hdl/aes_pkg.sv @@
// Shared types and constants for the AHDSR envelope evaluator.
`timescale 1ns / 1ps

package aes_pkg;

    // Fixed field widths
    localparam int SMP_W  = 48;   // sample positions, signed
    localparam int LEN_W  = 24;   // phase lengths
    localparam int SUS_W  = 17;   // sustain register
    localparam int LVL_W  = 17;   // output level
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Parameter defaults
    localparam int LEVEL_FRAC_BITS_DEF = 16;
    localparam int DURATION_BITS_DEF   = 24;

    // Register map, index = byte address / 4
    typedef enum logic [2:0] {
        REG_ATTACK  = 3'd0,
        REG_HOLD    = 3'd1,
        REG_DECAY   = 3'd2,
        REG_RELEASE = 3'd3,
        REG_SUSTAIN = 3'd4
    } t_reg_idx;

    // Envelope phase while the gate is held
    typedef enum logic [1:0] {
        PH_ATTACK,
        PH_FULL,
        PH_DECAY,
        PH_SUSTAIN
    } t_phase;

    typedef struct packed {
        logic [LEN_W-1:0] attack_len;
        logic [LEN_W-1:0] hold_len;
        logic [LEN_W-1:0] decay_len;
        logic [LEN_W-1:0] release_len;
        logic [SUS_W-1:0] sustain_level;
    } t_cfg;

    // Sideband that follows a request through the held-level divider
    typedef struct packed {
        logic             active;   // gate valid and query at or after begin
        logic             decay;    // quotient is a drop below full level
        logic             use_rel;  // second division is by release length
        logic [LEN_W-1:0] mult;     // factor applied to the held level
    } t_side;

endpackage

@@ hdl/aes_if.sv @@
// Request and response channel interfaces.
`timescale 1ns / 1ps

interface aes_req_if;
    logic                               valid;
    logic                               ready;
    logic signed [aes_pkg::SMP_W-1:0]   query_sample;
    logic signed [aes_pkg::SMP_W-1:0]   gate_begin;
    logic signed [aes_pkg::SMP_W-1:0]   gate_finish;
    logic                               gate_ok;

    modport source (output valid, query_sample, gate_begin, gate_finish, gate_ok,
                    input ready);
    modport sink   (input valid, query_sample, gate_begin, gate_finish, gate_ok,
                    output ready);
endinterface

interface aes_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [aes_pkg::LVL_W-1:0]  level;

    modport source (output valid, level, input ready);
    modport sink   (input valid, level, output ready);
endinterface

@@ hdl/aes_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module aes_div #(
    parameter int DW = 24,   // divisor width
    parameter int QW = 17,   // quotient width; numerator must be below den << QW
    parameter int SW = 1     // sideband width
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [DW+QW-1:0]   i_num,
    input  logic [DW-1:0]      i_den,
    input  logic [SW-1:0]      i_side,
    output logic               o_valid,
    output logic [QW-1:0]      o_quo,
    output logic [SW-1:0]      o_side
);

    // {partial remainder, remaining numerator bits / quotient bits}
    logic [DW+QW-1:0] r_x    [QW+1];
    logic [DW-1:0]    r_d    [QW+1];
    logic [SW-1:0]    r_s    [QW+1];
    logic             r_v    [QW+1];

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_x[0] <= i_num;
            r_d[0] <= i_den;
            r_s[0] <= i_side;
        end
    end

    // One subtract-and-compare per stage
    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [DW:0] t;
        logic        ge;
        logic [DW:0] n_rem;
        logic [DW+QW-1:0] n_x;

        assign t     = r_x[k-1][DW+QW-1:QW-1];
        assign ge    = (t >= {1'b0, r_d[k-1]});
        assign n_rem = ge ? (t - {1'b0, r_d[k-1]}) : t;
        if (QW > 1) begin : g_wide
            assign n_x = {n_rem[DW-1:0], r_x[k-1][QW-2:0], ge};
        end else begin : g_narrow
            assign n_x = {n_rem[DW-1:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
            if (i_en) begin
                r_x[k] <= n_x;
                r_d[k] <= r_d[k-1];
                r_s[k] <= r_s[k-1];
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_quo   = r_x[QW][QW-1:0];
    assign o_side  = r_s[QW];

endmodule

@@ hdl/aes_front.sv @@
// Front stages: gate offsets, saturation, phase pick and divider operands.
`timescale 1ns / 1ps

module aes_front #(
    parameter int LEVEL_FRAC_BITS = aes_pkg::LEVEL_FRAC_BITS_DEF,
    parameter int DURATION_BITS   = aes_pkg::DURATION_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_en,
    input  logic                                       i_valid,
    input  logic signed [aes_pkg::SMP_W-1:0]           i_query,
    input  logic signed [aes_pkg::SMP_W-1:0]           i_begin,
    input  logic signed [aes_pkg::SMP_W-1:0]           i_finish,
    input  logic                                       i_ok,
    input  aes_pkg::t_cfg                              i_cfg,
    output logic                                       o_valid,
    output logic [aes_pkg::LEN_W+LEVEL_FRAC_BITS:0]    o_num,
    output logic [aes_pkg::LEN_W-1:0]                  o_den,
    output aes_pkg::t_side                             o_side
);

    localparam int XW  = aes_pkg::SMP_W + 1;
    localparam int LW  = aes_pkg::LEN_W;
    localparam int DB  = DURATION_BITS;
    localparam int QW  = LEVEL_FRAC_BITS + 1;
    localparam int NW  = LW + QW;
    localparam int CW  = ((DB > LW + 2) ? DB : LW + 2) + 1;
    localparam int SW  = (QW > aes_pkg::SUS_W) ? QW : aes_pkg::SUS_W;
    localparam logic signed [XW-1:0] DMAX_X = XW'((64'd1 << DB) - 64'd1);
    localparam logic [QW-1:0] ONE = QW'(1) << LEVEL_FRAC_BITS;

    // Clamp a signed offset into the duration range
    function automatic logic [DB-1:0] sat_dur(input logic signed [XW-1:0] x);
        logic [DB-1:0] res;
        if (x <= 0) begin
            res = '0;
        end else if (x > DMAX_X) begin
            res = DMAX_X[DB-1:0];
        end else begin
            res = DB'(x);
        end
        return res;
    endfunction

    // Stage 1: offsets from gate begin
    logic                  r1_v, r1_ok;
    logic signed [XW-1:0]  r1_since, r1_held;
    logic signed [XW-1:0]  n1_since, n1_held;

    assign n1_since = XW'(i_query) - XW'(i_begin);
    assign n1_held  = XW'(i_finish) - XW'(i_begin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
        if (i_en) begin
            r1_ok    <= i_ok;
            r1_since <= n1_since;
            r1_held  <= n1_held[XW-1] ? '0 : n1_held;
        end
    end

    // Stage 2: held or released, saturated time, release factor
    logic                  r2_v, r2_active, r2_use_rel;
    logic [DB-1:0]         r2_h;
    logic [LW-1:0]         r2_mult;
    logic                  n2_relph, n2_live;
    logic signed [XW-1:0]  n2_r;
    logic [LW-1:0]         n2_mult;

    assign n2_relph = (r1_since >= r1_held);
    assign n2_r     = r1_since - r1_held;
    assign n2_live  = (i_cfg.release_len != '0) && (n2_r < XW'(i_cfg.release_len));

    always_comb begin
        if (!n2_relph) begin
            n2_mult = LW'(1);
        end else if (n2_live) begin
            n2_mult = i_cfg.release_len - n2_r[LW-1:0];
        end else begin
            n2_mult = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
        if (i_en) begin
            r2_active  <= r1_ok && !r1_since[XW-1];
            r2_use_rel <= n2_relph && n2_live;
            r2_h       <= n2_relph ? sat_dur(r1_held) : sat_dur(r1_since);
            r2_mult    <= n2_mult;
        end
    end

    // Stage 3: phase lookup
    logic                  r3_v;
    aes_pkg::t_phase       r3_phase;
    logic [LW-1:0]         r3_opnd;
    logic                  r3_active, r3_use_rel;
    logic [LW-1:0]         r3_mult;
    logic [CW-1:0]         a_end, h_end, d_end, hx, hdiff;
    aes_pkg::t_phase       n3_phase;

    assign a_end = CW'(i_cfg.attack_len);
    assign h_end = a_end + CW'(i_cfg.hold_len);
    assign d_end = h_end + CW'(i_cfg.decay_len);
    assign hx    = CW'(r2_h);
    assign hdiff = hx - h_end;

    always_comb begin
        priority if (hx < a_end) begin
            n3_phase = aes_pkg::PH_ATTACK;
        end else if (hx < h_end) begin
            n3_phase = aes_pkg::PH_FULL;
        end else if (hx < d_end) begin
            n3_phase = aes_pkg::PH_DECAY;
        end else begin
            n3_phase = aes_pkg::PH_SUSTAIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_en) begin
            r3_v <= r2_v;
        end
        if (i_en) begin
            r3_phase   <= n3_phase;
            r3_opnd    <= (n3_phase == aes_pkg::PH_DECAY) ? LW'(hdiff) : LW'(hx);
            r3_active  <= r2_active;
            r3_use_rel <= r2_use_rel;
            r3_mult    <= r2_mult;
        end
    end

    // Stage 4: numerator and divisor for the held level
    logic [SW-1:0]  sus_x;
    logic [QW-1:0]  sus_c, one_m_sus;
    logic [NW-1:0]  n4_num;
    logic [LW-1:0]  n4_den;
    logic           r4_v;
    logic [NW-1:0]  r4_num;
    logic [LW-1:0]  r4_den;
    aes_pkg::t_side r4_side;

    assign sus_x     = SW'(i_cfg.sustain_level);
    assign sus_c     = (sus_x > SW'(ONE)) ? ONE : QW'(sus_x);
    assign one_m_sus = ONE - sus_c;

    always_comb begin
        unique case (r3_phase)
            aes_pkg::PH_ATTACK: begin
                n4_num = NW'(r3_opnd) << LEVEL_FRAC_BITS;
                n4_den = i_cfg.attack_len;
            end
            aes_pkg::PH_FULL: begin
                n4_num = NW'(ONE);
                n4_den = LW'(1);
            end
            aes_pkg::PH_DECAY: begin
                n4_num = NW'(one_m_sus) * NW'(r3_opnd);
                n4_den = i_cfg.decay_len;
            end
            default: begin
                n4_num = NW'(sus_c);
                n4_den = LW'(1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (i_en) begin
            r4_v <= r3_v;
        end
        if (i_en) begin
            r4_num          <= n4_num;
            r4_den          <= n4_den;
            r4_side.active  <= r3_active;
            r4_side.decay   <= (r3_phase == aes_pkg::PH_DECAY);
            r4_side.use_rel <= r3_use_rel;
            r4_side.mult    <= r3_mult;
        end
    end

    assign o_valid = r4_v;
    assign o_num   = r4_num;
    assign o_den   = r4_den;
    assign o_side  = r4_side;

endmodule

@@ hdl/aes_rel.sv @@
// Release scaling: held level times remaining release, ready for division.
`timescale 1ns / 1ps

module aes_rel #(
    parameter int LEVEL_FRAC_BITS = aes_pkg::LEVEL_FRAC_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_en,
    input  logic                                       i_valid,
    input  logic [LEVEL_FRAC_BITS:0]                   i_quo,
    input  aes_pkg::t_side                             i_side,
    input  aes_pkg::t_cfg                              i_cfg,
    output logic                                       o_valid,
    output logic [aes_pkg::LEN_W+LEVEL_FRAC_BITS:0]    o_num,
    output logic [aes_pkg::LEN_W-1:0]                  o_den,
    output logic                                       o_active
);

    localparam int LW = aes_pkg::LEN_W;
    localparam int QW = LEVEL_FRAC_BITS + 1;
    localparam int NW = LW + QW;
    localparam logic [QW-1:0] ONE = QW'(1) << LEVEL_FRAC_BITS;

    logic [QW-1:0] l0;
    logic          r_v, r_active;
    logic [NW-1:0] r_num;
    logic [LW-1:0] r_den;

    // Held level: decay quotient is a drop from full level
    assign l0 = i_side.decay ? (ONE - i_quo) : i_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
        if (i_en) begin
            r_num    <= NW'(l0) * NW'(i_side.mult);
            r_den    <= i_side.use_rel ? i_cfg.release_len : LW'(1);
            r_active <= i_side.active;
        end
    end

    assign o_valid  = r_v;
    assign o_num    = r_num;
    assign o_den    = r_den;
    assign o_active = r_active;

endmodule

@@ hdl/ahdsr_envelope_evaluator_unit.sv @@
// Top level of the AHDSR envelope evaluator: config port, pipeline, output stage.
//
//   channel   dir   handshake       payload
//   i_req     in    valid/ready     query_sample, gate_begin, gate_finish, gate_ok
//   o_rsp     out   valid/ready     level
//   APB       in    psel/penable    paddr, pwdata -> prdata (pready tied high)
//
// One request enters per cycle unless the output is blocked. The pipeline holds
// four front stages, two dividers of LEVEL_FRAC_BITS+2 stages each
// (one quotient bit per stage), a release multiply stage and the output register.
// Reset is synchronous, clears all valid bits and the lengths, and sets sustain to full level.
// When the output holds an unaccepted response the whole pipeline freezes.
`timescale 1ns / 1ps

module ahdsr_envelope_evaluator_unit #(
    parameter int LEVEL_FRAC_BITS = aes_pkg::LEVEL_FRAC_BITS_DEF,
    parameter int DURATION_BITS   = aes_pkg::DURATION_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    aes_req_if.sink                      i_req,
    aes_rsp_if.source                    o_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [aes_pkg::ADDR_W-1:0]   paddr,
    input  logic [aes_pkg::DATA_W-1:0]   pwdata,
    output logic [aes_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    localparam int LW = aes_pkg::LEN_W;
    localparam int QW = LEVEL_FRAC_BITS + 1;
    localparam int NW = LW + QW;
    localparam int DW = aes_pkg::DATA_W;
    localparam logic [aes_pkg::SUS_W-1:0] SUS_RST =
        aes_pkg::SUS_W'(64'd1 << LEVEL_FRAC_BITS);
    localparam logic [QW-1:0] ONE = QW'(1) << LEVEL_FRAC_BITS;

    // Config registers
    aes_pkg::t_cfg r_cfg;
    logic [2:0]    reg_idx;
    logic          cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_len    <= '0;
            r_cfg.hold_len      <= '0;
            r_cfg.decay_len     <= '0;
            r_cfg.release_len   <= '0;
            r_cfg.sustain_level <= SUS_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                aes_pkg::REG_ATTACK:  r_cfg.attack_len    <= pwdata[LW-1:0];
                aes_pkg::REG_HOLD:    r_cfg.hold_len      <= pwdata[LW-1:0];
                aes_pkg::REG_DECAY:   r_cfg.decay_len     <= pwdata[LW-1:0];
                aes_pkg::REG_RELEASE: r_cfg.release_len   <= pwdata[LW-1:0];
                aes_pkg::REG_SUSTAIN: r_cfg.sustain_level <= pwdata[aes_pkg::SUS_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            aes_pkg::REG_ATTACK:  prdata = DW'(r_cfg.attack_len);
            aes_pkg::REG_HOLD:    prdata = DW'(r_cfg.hold_len);
            aes_pkg::REG_DECAY:   prdata = DW'(r_cfg.decay_len);
            aes_pkg::REG_RELEASE: prdata = DW'(r_cfg.release_len);
            aes_pkg::REG_SUSTAIN: prdata = DW'(r_cfg.sustain_level);
            default:              prdata = '0;
        endcase
    end

    // Pipeline advance: everything moves unless the output is blocked
    logic r_out_valid;
    logic en;

    assign en          = !r_out_valid || o_rsp.ready;
    assign i_req.ready = en;

    // Front stages
    logic           f_valid;
    logic [NW-1:0]  f_num;
    logic [LW-1:0]  f_den;
    aes_pkg::t_side f_side;

    aes_front #(
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS),
        .DURATION_BITS   (DURATION_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_req.valid),
        .i_query  (i_req.query_sample),
        .i_begin  (i_req.gate_begin),
        .i_finish (i_req.gate_finish),
        .i_ok     (i_req.gate_ok),
        .i_cfg    (r_cfg),
        .o_valid  (f_valid),
        .o_num    (f_num),
        .o_den    (f_den),
        .o_side   (f_side)
    );

    // Held level division
    logic           d1_valid;
    logic [QW-1:0]  d1_quo;
    aes_pkg::t_side d1_side;

    aes_div #(
        .DW (LW),
        .QW (QW),
        .SW ($bits(aes_pkg::t_side))
    ) u_div_held (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_num   (f_num),
        .i_den   (f_den),
        .i_side  (f_side),
        .o_valid (d1_valid),
        .o_quo   (d1_quo),
        .o_side  (d1_side)
    );

    // Release scaling
    logic          s_valid, s_active;
    logic [NW-1:0] s_num;
    logic [LW-1:0] s_den;

    aes_rel #(
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_rel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (d1_valid),
        .i_quo    (d1_quo),
        .i_side   (d1_side),
        .i_cfg    (r_cfg),
        .o_valid  (s_valid),
        .o_num    (s_num),
        .o_den    (s_den),
        .o_active (s_active)
    );

    // Release division
    logic          d2_valid;
    logic [QW-1:0] d2_quo;
    logic          d2_active;

    aes_div #(
        .DW (LW),
        .QW (QW),
        .SW (1)
    ) u_div_rel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_valid),
        .i_num   (s_num),
        .i_den   (s_den),
        .i_side  (s_active),
        .o_valid (d2_valid),
        .o_quo   (d2_quo),
        .o_side  (d2_active)
    );

    // Output register
    logic [QW-1:0] r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= d2_valid;
        end
        if (en) begin
            r_level <= d2_active ? d2_quo : '0;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.level = aes_pkg::LVL_W'(r_level);

    // Checks
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_rsp.valid)
        else $error("response valid right after reset");

    a_level_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (r_level <= ONE))
        else $error("envelope level above full scale");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=> (o_rsp.valid && $stable(r_level)
            && $stable(d2_valid)))
        else $error("pipeline moved while output blocked");

endmodule

@@ test/ahdsr_envelope_evaluator_unit_tb.sv @@
// Testbench for the AHDSR envelope evaluator: directed table, random requests, scoreboard.
`timescale 1ns / 1ps

module ahdsr_envelope_evaluator_unit_tb;

    localparam int     SMP_W   = aes_pkg::SMP_W;
    localparam int     LVL_W   = aes_pkg::LVL_W;
    localparam int     ADDR_W  = aes_pkg::ADDR_W;
    localparam int     DATA_W  = aes_pkg::DATA_W;
    localparam int     LAT     = 2 * aes_pkg::LEVEL_FRAC_BITS_DEF + 10;
    localparam longint ONE_LV  = 64'd1 << aes_pkg::LEVEL_FRAC_BITS_DEF;
    localparam longint DUR_MAX = (64'd1 << aes_pkg::DURATION_BITS_DEF) - 1;

    typedef struct {
        logic signed [SMP_W-1:0] query_sample;
        logic signed [SMP_W-1:0] gate_begin;
        logic signed [SMP_W-1:0] gate_finish;
        logic                    gate_ok;
        logic                    has_level;   // typed-in expectation present
        logic [LVL_W-1:0]        level;
    } t_query_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    aes_req_if req_ch ();
    aes_rsp_if rsp_ch ();

    ahdsr_envelope_evaluator_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .o_rsp(rsp_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the envelope registers
    longint unsigned atk_len, hld_len, dcy_len, rel_len, sus_reg;

    logic [LVL_W-1:0] level_fifo[$];
    int  fail_cnt = 0;
    int  levels_seen = 0;
    int  nonzero_seen = 0;
    int  queries_sent = 0;
    bit  idle_rx = 1'b1;        // random stalls on the response side
    bit  rx_hold_req = 1'b0;    // long receiver hold-off request

    initial begin
        req_ch.valid = 1'b0;
        req_ch.query_sample = '0;
        req_ch.gate_begin = '0;
        req_ch.gate_finish = '0;
        req_ch.gate_ok = 1'b0;
        rsp_ch.ready = 1'b0;
    end

    // Level while the gate is held, h already saturated
    function automatic longint unsigned held_env(longint unsigned h);
        longint unsigned sus, h_end, d_end;
        sus = (sus_reg > ONE_LV) ? ONE_LV : sus_reg;
        h_end = atk_len + hld_len;
        d_end = h_end + dcy_len;
        if (h == 0) begin
            if (atk_len > 0) return 0;
            if (hld_len > 0 || dcy_len > 0) return ONE_LV;
            return sus;
        end
        if (h < atk_len) return (h * ONE_LV) / atk_len;
        if (h < h_end) return ONE_LV;
        if (h < d_end) return ONE_LV - ((ONE_LV - sus) * (h - h_end)) / dcy_len;
        return sus;
    endfunction

    function automatic longint unsigned sat_span(longint x);
        if (x <= 0) return 0;
        if (x > DUR_MAX) return DUR_MAX;
        return x;
    endfunction

    function automatic logic [LVL_W-1:0] envelope_level(t_query_row r);
        longint q, b, f, held, since, rel;
        longint unsigned l0, lvl;
        q = r.query_sample;
        b = r.gate_begin;
        f = r.gate_finish;
        lvl = 0;
        if (r.gate_ok && q >= b) begin
            held = f - b;
            since = q - b;
            if (held < 0) held = 0;
            if (since < held) begin
                lvl = held_env(sat_span(since));
            end else begin
                l0 = held_env(sat_span(held));
                rel = since - held;
                if (rel_len != 0 && longint'(rel_len) > rel)
                    lvl = (l0 * (rel_len - rel)) / rel_len;
            end
        end
        return lvl[LVL_W-1:0];
    endfunction

    // APB write: setup then access cycle
    task automatic reg_write(aes_pkg::t_reg_idx idx, longint unsigned val);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= ADDR_W'(4 * int'(idx)); pwdata <= DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            aes_pkg::REG_ATTACK:  atk_len = val & 24'hFFFFFF;
            aes_pkg::REG_HOLD:    hld_len = val & 24'hFFFFFF;
            aes_pkg::REG_DECAY:   dcy_len = val & 24'hFFFFFF;
            aes_pkg::REG_RELEASE: rel_len = val & 24'hFFFFFF;
            aes_pkg::REG_SUSTAIN: sus_reg = val & 17'h1FFFF;
            default: ;
        endcase
    endtask

    task automatic set_envelope(longint unsigned a, h, d, rl, s);
        reg_write(aes_pkg::REG_ATTACK, a);
        reg_write(aes_pkg::REG_HOLD, h);
        reg_write(aes_pkg::REG_DECAY, d);
        reg_write(aes_pkg::REG_RELEASE, rl);
        reg_write(aes_pkg::REG_SUSTAIN, s);
    endtask

    // Wait until every level is back, then let the pipe drain
    task automatic drain_pipe();
        while (level_fifo.size() != 0) @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    // Offer one request, holding valid until it is accepted
    task automatic send_query(t_query_row r, bit gaps);
        logic [LVL_W-1:0] lv_exp;
        if (gaps) while ($urandom_range(99) < 27) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.query_sample <= r.query_sample;
        req_ch.gate_begin <= r.gate_begin;
        req_ch.gate_finish <= r.gate_finish;
        req_ch.gate_ok <= r.gate_ok;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        lv_exp = r.has_level ? r.level : envelope_level(r);
        level_fifo = {level_fifo, lv_exp};
        queries_sent++;
    endtask

    task automatic stop_sending();
        req_ch.valid <= 1'b0;
    endtask

    // Random request: mostly relative to the gate, sometimes full-range noise
    function automatic t_query_row rand_query(longint unsigned span);
        t_query_row r;
        longint b, hl;
        int sel;
        sel = $urandom_range(99);
        r.has_level = 1'b0;
        r.level = '0;
        r.gate_ok = ($urandom_range(9) != 0);
        if (sel < 8) begin
            r.query_sample = SMP_W'({$urandom, $urandom});
            r.gate_begin = SMP_W'({$urandom, $urandom});
            r.gate_finish = SMP_W'({$urandom, $urandom});
            r.gate_ok = ($urandom_range(1) != 0);
        end else begin
            b = longint'({$urandom, $urandom}) >>> 18;
            if ($urandom_range(3) == 0) b = -b;
            hl = $urandom_range(0, int'(span));
            if ($urandom_range(15) == 0) hl = -longint'($urandom_range(50));
            if ($urandom_range(20) == 0) hl = DUR_MAX + $urandom_range(3) - 1;
            r.gate_begin = SMP_W'(b);
            r.gate_finish = SMP_W'(b + hl);
            r.query_sample = SMP_W'(b + longint'($urandom_range(0, int'(2 * span + 4)))
                             - longint'($urandom_range(0, 3)));
            if ($urandom_range(30) == 0)
                r.query_sample = SMP_W'(b + DUR_MAX + $urandom_range(5));
        end
        return r;
    endfunction

    // Directed table
    t_query_row dir_rows[$];

    task automatic add_row(longint q, b, f, logic ok, logic has, longint unsigned lv);
        t_query_row r;
        r.query_sample = SMP_W'(q); r.gate_begin = SMP_W'(b); r.gate_finish = SMP_W'(f);
        r.gate_ok = ok;
        r.has_level = has; r.level = LVL_W'(lv);
        dir_rows = {dir_rows, r};
    endtask

    // Response side: random stalls, or a long hold-off on request
    initial begin
        int hold_cnt;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rsp_ch.ready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < 300; hold_cnt++) @(posedge i_clk);
                rx_hold_req = 1'b0;
                rsp_ch.ready <= 1'b1;
            end else begin
                rsp_ch.ready <= !(idle_rx && $urandom_range(99) < 27);
            end
        end
    end

    // Result checking
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (level_fifo.size() == 0) begin
                $display("%0t: unexpected level, expected none, actual %0d",
                         $time, rsp_ch.level);
                fail_cnt++;
            end else begin
                if (rsp_ch.level !== level_fifo[0]) begin
                    $display("%0t: level mismatch, expected %0d, actual %0d",
                             $time, level_fifo[0], rsp_ch.level);
                    fail_cnt++;
                end
                void'(level_fifo.pop_front());
            end
            levels_seen++;
            if (rsp_ch.level != 0) nonzero_seen++;
        end
    end

    initial begin
        #60_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        t_query_row r;
        longint unsigned span;
        longint maxs, mins;
        int k, phase;
        atk_len = 0; hld_len = 0; dcy_len = 0; rel_len = 0; sus_reg = ONE_LV;
        maxs = (64'sd1 <<< (SMP_W - 1)) - 1;
        mins = -(64'sd1 <<< (SMP_W - 1));
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // After reset all lengths are zero: held gate gives sustain, release gives 0
        add_row(0, 0, 10, 1, 1, ONE_LV);          // zero held time, sustain
        add_row(5, 0, 10, 1, 1, ONE_LV);
        add_row(10, 0, 10, 1, 1, 0);              // zero release
        add_row(-1, 0, 10, 1, 1, 0);              // before gate
        add_row(5, 0, 10, 0, 1, 0);               // invalid gate
        add_row(maxs - 1, mins, maxs, 1, 1, ONE_LV);  // saturated durations
        add_row(mins, maxs, mins, 1, 1, 0);
        add_row(maxs, mins, mins, 1, 1, 0);       // finish at begin
        for (k = 0; k < dir_rows.size(); k++) send_query(dir_rows[k], 0);
        stop_sending();
        drain_pipe();

        // Extremes of the registers and every phase
        set_envelope(10, 5, 20, 30, 32768);
        dir_rows.delete();
        add_row(100, 100, 100, 1, 1, 0);          // zero held, attack > 0
        add_row(105, 100, 200, 1, 0, 0);          // attack
        add_row(112, 100, 200, 1, 1, ONE_LV);     // hold
        add_row(125, 100, 200, 1, 0, 0);          // decay
        add_row(150, 100, 200, 1, 1, 32768);      // sustain
        add_row(210, 100, 200, 1, 0, 0);          // release
        add_row(230, 100, 200, 1, 1, 0);          // release elapsed
        add_row(105, 100, 50, 1, 0, 0);           // finish before begin
        add_row(115, 100, 108, 1, 0, 0);          // release from attack
        for (k = 0; k < dir_rows.size(); k++) send_query(dir_rows[k], 0);
        stop_sending();
        drain_pipe();

        set_envelope(0, 3, 0, 24'hFFFFFF, 17'h1FFFF);  // sustain clamped
        dir_rows.delete();
        add_row(0, 0, 0, 1, 1, ONE_LV);
        add_row(1, 0, 0, 1, 0, 0);
        add_row(maxs, 0, maxs, 1, 0, 0);
        add_row(maxs, 0, 5, 1, 0, 0);
        for (k = 0; k < dir_rows.size(); k++) send_query(dir_rows[k], 0);
        stop_sending();
        drain_pipe();

        set_envelope(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1, 0);
        dir_rows.delete();
        add_row(123456, 0, maxs, 1, 0, 0);
        add_row(24'hFFFFFE, 0, maxs, 1, 0, 0);
        add_row(maxs, mins, maxs, 1, 0, 0);
        add_row(100, 0, 100, 1, 1, 0);
        for (k = 0; k < dir_rows.size(); k++) send_query(dir_rows[k], 0);
        stop_sending();
        drain_pipe();

        // Random phases, each with its own envelope setting
        for (phase = 0; phase < 10; phase++) begin
            case (phase % 4)
                0: span = 40;
                1: span = 400;
                2: span = 5000;
                default: span = 60;
            endcase
            set_envelope($urandom_range(0, int'(span)), $urandom_range(0, int'(span)),
                         $urandom_range(0, int'(span)), $urandom_range(0, int'(span)),
                         ($urandom_range(7) == 0) ? $urandom_range(65537, 131071)
                                                  : $urandom_range(0, 65536));
            if (phase == 9)
                set_envelope(0, 0, 0, $urandom_range(0, 1) ? 0 : 24'hFFFFFF,
                             $urandom_range(0, 65536));
            idle_rx = (phase != 2);
            for (k = 0; k < 200; k++) begin
                r = rand_query(3 * span);
                if (phase == 4 && k == 20) rx_hold_req = 1'b1;
                if (k == 100) begin
                    stop_sending();
                    while (level_fifo.size() != 0) @(posedge i_clk);
                end
                send_query(r, phase != 2);
            end
            stop_sending();
            drain_pipe();
        end
        idle_rx = 1'b1;

        // Random values in every field
        for (k = 0; k < 60; k++) begin
            r.query_sample = SMP_W'({$urandom, $urandom});
            r.gate_begin = SMP_W'({$urandom, $urandom});
            r.gate_finish = SMP_W'({$urandom, $urandom});
            r.gate_ok = k[0];
            r.has_level = 1'b0; r.level = '0;
            send_query(r, 1);
        end
        stop_sending();
        drain_pipe();

        $display("Sent %0d queries over 14 envelope settings; %0d levels checked, %0d non-zero.",
                 queries_sent, levels_seen, nonzero_seen);
        if (fail_cnt == 0 && level_fifo.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
